// ===== rtl/abl_pkg.sv =====
// Package with shared constants, types and the interpolation unit interface types.
package abl_pkg;

  localparam int unsigned MaxAngles  = 32;
  localparam int unsigned MaxRadii   = 32;
  localparam int unsigned TableDepth = (MaxRadii + 1) * MaxAngles;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned RadAddrW   = $clog2(MaxRadii);
  localparam int unsigned AngIdxW    = $clog2(MaxAngles);
  localparam int unsigned RadIdxW    = $clog2(MaxRadii);
  localparam logic [15:0] DegScale   = 16'd58671;

  typedef enum logic [1:0] {
    ActWriteTable  = 2'd0,
    ActWriteRadius = 2'd1,
    ActEvaluate    = 2'd2,
    ActUnused      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegionBelow  = 2'd0,
    RegionInside = 2'd1,
    RegionAbove  = 2'd2,
    RegionNone   = 2'd3
  } region_e;

  localparam logic [0:0] CfgAngleCount  = 1'b0;
  localparam logic [0:0] CfgRadiusCount = 1'b1;

  // Request and response of the shared interpolation unit.
  typedef struct packed {
    logic        start;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] x;
    logic [15:0] y0;
    logic [15:0] y1;
  } lerp_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] y;
  } lerp_rsp_t;

endpackage

// ===== rtl/anisotropy_bilinear_lookup_unit.sv =====
// Top level: table memories, bin search sequencer and bilinear interpolation control.
//
// An evaluate transaction keeps busy high up to and including the result strobe: each binary
// search issues a midpoint read and a compare per step (up to five steps over 32 breakpoints)
// and then closes, the angle and radius bounds are read, then two or four table values, then
// one or three interpolations, each made of start, multiply, 32 bit-serial divide steps and
// hand-over, or of start and hand-over alone when its interval is empty. Writes may follow
// each other back to back. The result is shown for one cycle and cannot be held off; the
// receiver cannot stall.
// No clearing pass is needed after reset.
module anisotropy_bilinear_lookup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  input  logic [1:0]  action_i,
  input  logic [10:0] slot_i,
  input  logic [15:0] word_i,
  input  logic [15:0] radius_i,
  input  logic [14:0] polar_angle_i,
  output logic        valid_o,
  output logic [15:0] anisotropy_o,
  output logic [1:0]  region_o
);
  import abl_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SAngSearch, SAngRead, SRadCheck, SRadSearch, SRadRead,
    SRowRead, SLerpLo, SLerpHi, SLerpAng, SDone
  } state_e;

  logic [15:0] tbl_mem [TableDepth];
  logic [15:0] rad_mem [MaxRadii];
  logic [15:0] tbl_rd_q, rad_rd_q;
  logic [AddrW-1:0] tbl_addr;
  logic [RadAddrW-1:0] rad_addr;

  logic [5:0] na_cfg_q, nr_cfg_q;
  state_e state_q;
  logic [3:0] sub_q;
  logic [5:0] lo_q, hi_q;
  logic [15:0] deg_q, r_q;
  logic [5:0] na_q, nr_q;
  logic [AngIdxW-1:0] j_q;
  logic [RadIdxW-1:0] k_q;
  logic [1:0] region_q;
  logic [15:0] a0_q, a1_q, r0_q, r1_q;
  logic [15:0] v_q [4];
  logic [15:0] lower_q;
  logic [15:0] res_q;
  logic valid_q;
  logic [5:0] mid;
  logic [31:0] deg_full;
  logic [5:0] na_c, nr_c;
  lerp_req_t lreq;
  lerp_rsp_t lrsp;
  logic accept;

  assign accept = start && !busy;
  assign mid = 6'((7'(lo_q) + 7'(hi_q)) >> 1);
  assign deg_full = 32'(polar_angle_i) * 32'(DegScale);
  assign na_c = (na_cfg_q < 6'd2) ? 6'd2 : (na_cfg_q > 6'(MaxAngles) ? 6'(MaxAngles) : na_cfg_q);
  assign nr_c = (nr_cfg_q < 6'd2) ? 6'd2 : (nr_cfg_q > 6'(MaxRadii) ? 6'(MaxRadii) : nr_cfg_q);

  // Flat table address: row index times the angle count, plus the column.
  function automatic logic [AddrW-1:0] flat(input logic [5:0] row, input logic [5:0] n,
                                            input logic [AngIdxW:0] col);
    logic [AddrW+1:0] p;
    p = (AddrW+2)'(row) * (AddrW+2)'(n) + (AddrW+2)'(col);
    return p[AddrW-1:0];
  endfunction

  always_comb begin
    tbl_addr = '0;
    rad_addr = '0;
    case (state_q)
      SAngSearch: tbl_addr = AddrW'(mid);
      SAngRead: tbl_addr = AddrW'(sub_q[0] ? {1'b0, j_q} + 6'd1 : {1'b0, j_q});
      SRadCheck: rad_addr = sub_q[0] ? RadAddrW'(nr_q - 6'd1) : '0;
      SRadSearch: rad_addr = RadAddrW'(mid);
      SRadRead: rad_addr = sub_q[0] ? k_q + RadAddrW'(1) : k_q;
      SRowRead: begin
        case (region_q)
          RegionBelow: tbl_addr = flat(6'd1, na_q, {1'b0, j_q} + (AngIdxW+1)'(sub_q[0]));
          RegionAbove: tbl_addr = flat(nr_q, na_q, {1'b0, j_q} + (AngIdxW+1)'(sub_q[0]));
          default: tbl_addr = flat(6'(k_q) + 6'd1 + 6'(sub_q[1]), na_q,
                                   {1'b0, j_q} + (AngIdxW+1)'(sub_q[0]));
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && action_i == ActWriteTable && 32'(slot_i) < TableDepth) begin
      tbl_mem[AddrW'(slot_i)] <= word_i;
    end
    if (accept && action_i == ActWriteRadius && 32'(slot_i) < MaxRadii) begin
      rad_mem[RadAddrW'(slot_i)] <= word_i;
    end
    tbl_rd_q <= tbl_mem[tbl_addr];
    rad_rd_q <= rad_mem[rad_addr];
  end

  always_comb begin
    lreq = '0;
    case (state_q)
      SLerpLo: lreq = '{start: sub_q == 4'd0, x0: r0_q, x1: r1_q, x: r_q, y0: v_q[0], y1: v_q[2]};
      SLerpHi: lreq = '{start: sub_q == 4'd0, x0: r0_q, x1: r1_q, x: r_q, y0: v_q[1], y1: v_q[3]};
      SLerpAng: lreq = '{start: sub_q == 4'd0, x0: a0_q, x1: a1_q, x: deg_q,
                        y0: (region_q == RegionInside) ? lower_q : v_q[0],
                        y1: (region_q == RegionInside) ? res_q : v_q[1]};
      default: ;
    endcase
  end

  abl_lerp u_lerp (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(lreq), .rsp_o(lrsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      na_cfg_q <= 6'd2;
      nr_cfg_q <= 6'd2;
      valid_q  <= 1'b0;
      sub_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgAngleCount) na_cfg_q <= cfg_data_i;
        else nr_cfg_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (accept && action_i == ActEvaluate) begin
            deg_q   <= deg_full[31:16];
            r_q     <= radius_i;
            na_q    <= na_c;
            nr_q    <= nr_c;
            lo_q    <= '0;
            hi_q    <= na_c - 6'd1;
            sub_q   <= '0;
            state_q <= SAngSearch;
          end
        end
        SAngSearch: begin
          // sub 0 issues the read of the midpoint, sub 1 compares.
          if (hi_q - lo_q <= 6'd1) begin
            j_q     <= AngIdxW'(lo_q);
            sub_q   <= '0;
            state_q <= SAngRead;
          end else if (sub_q == 4'd0) begin
            sub_q <= 4'd1;
          end else begin
            if (tbl_rd_q <= deg_q) lo_q <= mid;
            else hi_q <= mid;
            sub_q <= '0;
          end
        end
        SAngRead: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) a0_q <= tbl_rd_q;
          if (sub_q == 4'd2) begin
            a1_q    <= tbl_rd_q;
            sub_q   <= '0;
            state_q <= SRadCheck;
          end
        end
        SRadCheck: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) r0_q <= rad_rd_q;
          if (sub_q == 4'd2) begin
            sub_q <= '0;
            lo_q  <= '0;
            hi_q  <= nr_q - 6'd1;
            if (r_q < r0_q) begin
              region_q <= RegionBelow;
              state_q  <= SRowRead;
            end else if (r_q <= rad_rd_q) begin
              region_q <= RegionInside;
              state_q  <= SRadSearch;
            end else begin
              region_q <= RegionAbove;
              state_q  <= SRowRead;
            end
          end
        end
        SRadSearch: begin
          if (hi_q - lo_q <= 6'd1) begin
            k_q     <= RadIdxW'(lo_q);
            sub_q   <= '0;
            state_q <= SRadRead;
          end else if (sub_q == 4'd0) begin
            sub_q <= 4'd1;
          end else begin
            if (rad_rd_q <= r_q) lo_q <= mid;
            else hi_q <= mid;
            sub_q <= '0;
          end
        end
        SRadRead: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) r0_q <= rad_rd_q;
          if (sub_q == 4'd2) begin
            r1_q    <= rad_rd_q;
            sub_q   <= '0;
            state_q <= SRowRead;
          end
        end
        SRowRead: begin
          // Issue order 0..3 (0..1 outside the radius range); data of issue n is captured in the following cycle.
          sub_q <= sub_q + 4'd1;
          if (sub_q != 4'd0) v_q[sub_q[1:0] - 2'd1] <= tbl_rd_q;
          if (sub_q == 4'd4 || (region_q != RegionInside && sub_q == 4'd2)) begin
            sub_q   <= '0;
            state_q <= (region_q == RegionInside) ? SLerpLo : SLerpAng;
          end
        end
        SLerpLo: begin
          sub_q <= 4'd1;
          if (lrsp.done) begin
            lower_q <= lrsp.y;
            sub_q   <= '0;
            state_q <= SLerpHi;
          end
        end
        SLerpHi: begin
          sub_q <= 4'd1;
          if (lrsp.done) begin
            res_q   <= lrsp.y;
            sub_q   <= '0;
            state_q <= SLerpAng;
          end
        end
        SLerpAng: begin
          sub_q <= 4'd1;
          if (lrsp.done) begin
            res_q   <= lrsp.y;
            valid_q <= 1'b1;
            sub_q   <= '0;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy         = (state_q != SIdle) || valid_q;
  assign valid_o      = valid_q;
  assign anisotropy_o = res_q;
  assign region_o     = region_q;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == SLerpAng)) else $error("result without final interpolation");
  a_region_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (region_o != RegionNone)) else $error("invalid region code");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == SIdle) else $error("sequencer active during result");
`endif

endmodule

// ===== rtl/abl_lerp.sv =====
// Multi-cycle linear interpolation unit with a restoring bit-serial divider.
module abl_lerp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abl_pkg::lerp_req_t req_i,
  output abl_pkg::lerp_rsp_t rsp_o
);
  import abl_pkg::*;

  typedef enum logic [1:0] {
    LIdle,
    LMul,
    LDiv
  } lstate_e;

  lstate_e     state_q;
  logic [4:0]  cnt_q;
  logic [15:0] y0_q;
  logic        neg_q;
  logic [15:0] dy_q;
  logic [15:0] dx_q;
  logic [15:0] den_q;
  logic [31:0] num_q;
  logic [16:0] rem_q;
  logic [31:0] quo_q;
  logic        done_q;
  logic [15:0] res_q;

  logic [15:0] xc;
  logic        neg;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] qmag;

  always_comb begin
    if (req_i.x < req_i.x0) begin
      xc = req_i.x0;
    end else if (req_i.x > req_i.x1) begin
      xc = req_i.x1;
    end else begin
      xc = req_i.x;
    end
    neg     = req_i.y1 < req_i.y0;
    rem_sh  = {rem_q[15:0], num_q[31]};
    rem_sub = rem_sh - {1'b0, den_q};
    // The quotient never exceeds |y1 - y0|, so 16 bits suffice.
    qmag    = quo_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        LIdle: begin
          if (req_i.start) begin
            y0_q <= req_i.y0;
            if (req_i.x1 <= req_i.x0) begin
              res_q  <= req_i.y0;
              done_q <= 1'b1;
            end else begin
              neg_q   <= neg;
              dy_q    <= neg ? req_i.y0 - req_i.y1 : req_i.y1 - req_i.y0;
              dx_q    <= xc - req_i.x0;
              den_q   <= req_i.x1 - req_i.x0;
              state_q <= LMul;
            end
          end
        end
        LMul: begin
          num_q   <= 32'(dy_q) * 32'(dx_q);
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= LDiv;
        end
        LDiv: begin
          num_q <= {num_q[30:0], 1'b0};
          if (!rem_sub[16]) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= LIdle;
          end
        end
        default: state_q <= LIdle;
      endcase
    end
  end

  // The final quotient is available the cycle after the last divide step.
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= (state_q == LDiv) && (cnt_q == 5'd31);
    end
  end

  assign rsp_o.done = done_q | fin_q;
  assign rsp_o.y    = fin_q ? (neg_q ? y0_q - qmag : y0_q + qmag) : res_q;

endmodule
